@@ rtl/ordered_value_list_engine_top_assert.svh @@
// assertion macros shared by the list engine modules
// no dependencies; included by files that carry concurrent checks
`ifndef ORDERED_VALUE_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_VALUE_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define OVLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define OVLE_NEVER(lbl, clk, rst_n, cond, msg) \
  `OVLE_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define OVLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define OVLE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/ovle_pkg.sv @@
// shared constants, codes and controller/datapath bundles of the list engine
// no dependencies
package ovle_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_READ_ALL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_RA_RD,
    S_RA_CAP,
    S_RA_OUT,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PTR_DN,
    RD_PTR_UP
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_TAIL,
    WR_PTR,
    WR_POS
  } wr_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_inc;
    logic    ptr_from_count;
    logic    ptr_from_idx;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_from_rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic idx_at_count;
    logic match;
    logic ptr_at_pos;
    logic del_end;
    logic ra_last;
  } dp_stat_t;

endpackage

@@ rtl/ovle_if.sv @@
// valid/ready channel interfaces for list commands and list results
// depends on ovle_pkg
interface ovle_cmd_if;
  import ovle_pkg::*;
  logic  valid;
  logic  ready;
  logic  [1:0] command;
  data_t item_value;
  data_t anchor_value;

  modport source (output valid, output command, output item_value, output anchor_value,
                  input ready);
  modport sink (input valid, input command, input item_value, input anchor_value,
                output ready);
endinterface

interface ovle_res_if;
  import ovle_pkg::*;
  logic  valid;
  logic  ready;
  logic  [1:0] status;
  data_t read_value;
  logic  is_last;
  logic  [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output is_last,
                  output entry_count, input ready);
  modport sink (input valid, input status, input read_value, input is_last,
                input entry_count, output ready);
endinterface

@@ rtl/ovle_ctrl.sv @@
// sequencing state machine of the list engine
// depends on ovle_pkg and ordered_value_list_engine_top_assert.svh
`include "ordered_value_list_engine_top_assert.svh"

module ovle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ovle_pkg::dp_stat_t stat_i,
  output ovle_pkg::dp_cmd_t  cmd_o
);
  import ovle_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_APPEND: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.wr_en      = 1'b1;
              cmd_o.wr_sel     = WR_TAIL;
              cmd_o.cnt_inc    = 1'b1;
              cmd_o.res_status = ST_OK;
            end
            state_d = S_RESULT;
          end
          CMD_INSERT, CMD_DELETE: begin
            state_d = S_SRCH_RD;
          end
          CMD_READ_ALL: begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_RESULT;
            end else begin
              state_d = S_RA_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SRCH_RD: begin
        if (stat_i.idx_at_count) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESULT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (!stat_i.match) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SRCH_RD;
        end else if (stat_i.cmd == CMD_DELETE) begin
          cmd_o.ptr_from_idx = 1'b1;
          state_d            = S_DEL_RD;
        end else if (stat_i.full) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_RESULT;
        end else begin
          cmd_o.ptr_from_count = 1'b1;
          state_d              = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (stat_i.ptr_at_pos) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_POS;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_RESULT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_DN;
          state_d      = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_PTR;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat_i.del_end) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_RESULT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_UP;
          state_d      = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_PTR;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DEL_RD;
      end
      S_RA_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_RA_CAP;
      end
      S_RA_CAP: begin
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_OK;
        cmd_o.res_from_rd = 1'b1;
        state_d           = S_RA_OUT;
      end
      S_RA_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.ra_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RA_RD;
          end
        end
      end
      S_RESULT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `OVLE_NEVER(a_ready_while_result, clk_i, rst_ni, in_ready_o && out_valid_o, "input open while a result is pending")
  `OVLE_NEVER(a_rd_wr_same_cycle, clk_i, rst_ni, cmd_o.rd_en && cmd_o.wr_en, "memory read and write in one cycle")
  `OVLE_ASSERT(a_single_done_idle, clk_i, rst_ni, (state_q == S_RESULT && out_ready_i) |=> in_ready_o, "no return to idle after single result")

endmodule

@@ rtl/ovle_dp.sv @@
// list storage, index registers, comparator and result register
// depends on ovle_pkg and ordered_value_list_engine_top_assert.svh
`include "ordered_value_list_engine_top_assert.svh"

module ovle_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        command_i,
  input  ovle_pkg::data_t                   item_value_i,
  input  ovle_pkg::data_t                   anchor_value_i,
  input  ovle_pkg::dp_cmd_t                 cmd_i,
  output ovle_pkg::dp_stat_t                stat_o,
  output logic [1:0]                        status_o,
  output ovle_pkg::data_t                   read_value_o,
  output logic                              is_last_o,
  output logic [ovle_pkg::COUNT_OUT_W-1:0]  entry_count_o
);
  import ovle_pkg::*;

  data_t   entry_mem_q [CAPACITY];
  data_t   rdata_q;
  cmd_e    cmd_q;
  data_t   item_q, anchor_q;
  cnt_t    count_q, idx_q, ptr_q;
  status_e status_q;
  data_t   value_q;
  logic    last_q;

  cnt_t             ptr_dn, ptr_up, idx_up, rd_addr_full, wr_addr_full;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  data_t            wr_data, key;

  assign ptr_dn = ptr_q - cnt_t'(1);
  assign ptr_up = ptr_q + cnt_t'(1);
  assign idx_up = idx_q + cnt_t'(1);
  assign key    = (cmd_q == CMD_INSERT) ? anchor_q : item_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR_DN: rd_addr_full = ptr_dn;
      RD_PTR_UP: rd_addr_full = ptr_up;
      default:   rd_addr_full = idx_q;
    endcase
    case (cmd_i.wr_sel)
      WR_PTR:  wr_addr_full = ptr_q;
      WR_POS:  wr_addr_full = idx_q;
      default: wr_addr_full = count_q;
    endcase
    wr_data = (cmd_i.wr_sel == WR_PTR) ? rdata_q : item_q;
  end

  assign rd_addr = rd_addr_full[IDX_W-1:0];
  assign wr_addr = wr_addr_full[IDX_W-1:0];

  // single-port style store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= cmd_e'(command_i);
      item_q   <= item_value_i;
      anchor_q <= anchor_value_i;
    end
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      value_q  <= cmd_i.res_from_rd ? rdata_q : '0;
      last_q   <= cmd_i.res_from_rd ? stat_o.ra_last : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + cnt_t'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - cnt_t'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_up;
      end
      if (cmd_i.ptr_from_count) begin
        ptr_q <= count_q;
      end else if (cmd_i.ptr_from_idx) begin
        ptr_q <= idx_q;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_dn;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_up;
      end
    end
  end

  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.full         = (count_q == cnt_t'(CAPACITY));
    stat_o.empty        = (count_q == '0);
    stat_o.idx_at_count = (idx_q == count_q);
    stat_o.match        = (rdata_q == key);
    stat_o.ptr_at_pos   = (ptr_q == idx_q);
    stat_o.del_end      = (ptr_up == count_q);
    stat_o.ra_last      = (idx_up == count_q);
  end

  assign status_o      = status_q;
  assign read_value_o  = value_q;
  assign is_last_o     = last_q;
  assign entry_count_o = COUNT_OUT_W'(count_q);

  `OVLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= cnt_t'(CAPACITY), "entry count above capacity")
  `OVLE_ASSERT(a_wr_in_range, clk_i, rst_ni, cmd_i.wr_en |-> (wr_addr_full < cnt_t'(CAPACITY)), "store write beyond capacity")
  `OVLE_ASSERT(a_count_step, clk_i, rst_ni, (count_q == $past(count_q)) || (count_q == $past(count_q) + cnt_t'(1)) || (count_q + cnt_t'(1) == $past(count_q)), "entry count jumped")

endmodule

@@ rtl/ordered_value_list_engine_top.sv @@
// top level of the ordered value list engine: controller plus datapath
// depends on ovle_pkg, ovle_if, ovle_ctrl and ovle_dp
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------------
//   cmd_i    | in  | valid / ready | command, item_value, anchor_value
//   res_o    | out | valid / ready | status, read_value, is_last, entry_count
//
// one command is worked at a time; cmd_i.ready is high only while idle
// every access goes through the single store port, one access per cycle:
//   append writes the tail; search reads then compares each entry visited; insert
//   and delete shift each entry by a read then a write; read all returns each entry
// reset empties the list at once; store contents are not cleared
// a stalled result holds the engine in place until res_o.ready
module ordered_value_list_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ovle_cmd_if.sink   cmd_i,
  ovle_res_if.source res_o
);
  import ovle_pkg::*;

  // command and status bundles between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: owns both handshakes
  ovle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // datapath: list store, search/shift pointers, result register
  ovle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (cmd_i.command),
    .item_value_i   (cmd_i.item_value),
    .anchor_value_i (cmd_i.anchor_value),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .status_o       (res_o.status),
    .read_value_o   (res_o.read_value),
    .is_last_o      (res_o.is_last),
    .entry_count_o  (res_o.entry_count)
  );

endmodule

@@ sim/ordered_value_list_engine_top_test.sv @@
// testbench for ordered_value_list_engine_top: directed, random and backpressure traffic
// depends on ovle_pkg, ovle_if and the list engine rtl
`timescale 1ns / 100ps

module ordered_value_list_engine_top_test;
  import ovle_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 200;
  localparam int PRESSURE_ITEMS = 12;
  // receiver hold-off long enough to park a result and back up the command side
  localparam int RX_HOLD_CYCLES = 400;
  // idle margin after the last expected result to catch stray transactions
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  // one expected result transaction
  typedef struct {
    status_e                status;
    data_t                  read_value;
    logic                   is_last;
    logic [COUNT_OUT_W-1:0] entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  ovle_cmd_if cmd_ch ();
  ovle_res_if res_ch ();

  ordered_value_list_engine_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  // predicted list contents, head first, and results still owed by the engine
  data_t        model_entries[$];
  list_result_t expected_results[$];
  data_t        value_pool[8];

  int       error_count;
  int       result_index;
  int       burst_left;
  int       stall_cycles;
  bit       tx_steady;
  bit       hold_req;
  rx_mode_e rx_mode;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // list predictor
  // ---------------------------------------------------------------------------

  // index of the first entry equal to v, -1 when absent
  function automatic int find_entry(data_t v);
    for (int i = 0; i < model_entries.size(); i++) begin
      if (model_entries[i] == v) return i;
    end
    return -1;
  endfunction

  // update the predicted list for one accepted command and queue its results
  task automatic apply_list_command(cmd_e cmd, data_t item, data_t anchor);
    int           pos;
    list_result_t r;
    r.status     = ST_OK;
    r.read_value = '0;
    r.is_last    = 1'b1;
    case (cmd)
      CMD_APPEND: begin
        if (model_entries.size() >= CAPACITY) r.status = ST_FULL;
        else model_entries.push_back(item);
      end
      CMD_INSERT: begin
        // the anchor search comes first, so an absent anchor wins over full
        pos = find_entry(anchor);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else if (model_entries.size() >= CAPACITY) r.status = ST_FULL;
        else model_entries.insert(pos, item);
      end
      CMD_DELETE: begin
        pos = find_entry(item);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else model_entries.delete(pos);
      end
      CMD_READ_ALL: begin
        if (model_entries.size() == 0) r.status = ST_EMPTY;
        else begin
          // one transaction per entry, last marker on the tail
          r.entry_count = COUNT_OUT_W'(model_entries.size());
          for (int i = 0; i < model_entries.size(); i++) begin
            r.read_value = model_entries[i];
            r.is_last    = (i == model_entries.size() - 1);
            expected_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_OUT_W'(model_entries.size());
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // command sender: bursts of random length, random gaps in between unless tx_steady
  // called at a falling edge, returns at a falling edge with valid still high
  // ---------------------------------------------------------------------------
  task automatic send_item(cmd_e cmd, data_t item, data_t anchor);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (!tx_steady) begin
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
          // idle payload is noise the engine must ignore
          cmd_ch.valid        = 1'b0;
          cmd_ch.command      = 2'($urandom);
          cmd_ch.item_value   = $urandom;
          cmd_ch.anchor_value = $urandom;
          repeat (gap) @(negedge clk);
        end
      end
    end
    burst_left--;
    cmd_ch.valid        = 1'b1;
    cmd_ch.command      = cmd;
    cmd_ch.item_value   = item;
    cmd_ch.anchor_value = anchor;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_list_command(cmd, item, anchor);
    @(negedge clk);
  endtask

  // value from the current list, from the shared pool, or fully random
  function automatic data_t pick_value(int list_pct);
    int r;
    r = $urandom_range(0, 99);
    if (model_entries.size() > 0 && r < list_pct)
      return model_entries[$urandom_range(0, model_entries.size() - 1)];
    if (r < list_pct + (100 - list_pct) / 2)
      return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // result receiver: stalls by mode, with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    logic [7:0] rx_pattern;
    int         rx_phase;
    res_ch.ready = 1'b0;
    rx_pattern   = 8'hb5;
    rx_phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off counted here so the sender keeps pushing meanwhile
        hold_req     = 1'b0;
        res_ch.ready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (rx_phase % 32 == 0) rx_pattern = 8'($urandom) | 8'h01;
        case (rx_mode)
          RX_ALWAYS:  res_ch.ready = 1'b1;
          RX_RANDOM:  res_ch.ready = ($urandom_range(0, 99) < 65);
          RX_PATTERN: res_ch.ready = rx_pattern[rx_phase % 8];
          default:    res_ch.ready = 1'b1;
        endcase
        rx_phase++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: compares every result transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: result %0d %s mismatch, got %h expected %h",
             $time, result_index, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", {30'b0, res_ch.status}, '0);
      end else begin
        want = expected_results.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch("status", {30'b0, res_ch.status}, {30'b0, want.status});
        if (res_ch.read_value !== want.read_value)
          report_mismatch("read_value", res_ch.read_value, want.read_value);
        if (res_ch.is_last !== want.is_last)
          report_mismatch("is_last", {31'b0, res_ch.is_last}, {31'b0, want.is_last});
        if (res_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", {27'b0, res_ch.entry_count},
                          {27'b0, want.entry_count});
      end
      result_index++;
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // read all, delete and insert on an empty list
  task automatic test_empty_list();
    send_item(CMD_READ_ALL, 32'sd0, 32'sd0);
    send_item(CMD_DELETE, 32'sd5, 32'sd0);
    send_item(CMD_INSERT, 32'sd7, 32'sd7);
  endtask

  // fill to capacity with extreme values, then hit the full cases and read all
  task automatic test_fill_and_full();
    data_t fill_values[15];
    fill_values = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                    32'h5555_5555, 32'haaaa_aaaa, 32'sd1, -32'sd2, 32'sd42, 32'sd42,
                    32'sd100, -32'sd100, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'sd9};
    foreach (fill_values[i]) send_item(CMD_APPEND, fill_values[i], $urandom);
    // insert before the head brings the list to capacity
    send_item(CMD_INSERT, 32'sd13, 32'h8000_0000);
    send_item(CMD_APPEND, 32'sd3, 32'sd0);
    // anchor present on a full list
    send_item(CMD_INSERT, 32'sd5, 32'sd42);
    // anchor absent on a full list
    send_item(CMD_INSERT, 32'sd5, 32'sd12345);
    send_item(CMD_READ_ALL, $urandom, $urandom);
  endtask

  // delete first of a duplicate, an absent value and the tail
  task automatic test_delete_cases();
    send_item(CMD_DELETE, 32'sd42, 32'sd0);
    send_item(CMD_DELETE, 32'sd77, 32'sd0);
    send_item(CMD_DELETE, 32'sd9, 32'sd0);
    send_item(CMD_READ_ALL, 32'sd0, 32'sd0);
  endtask

  // random command mix, alternating fill and drain phases so the list
  // swings between empty and full, with changing idle modes on both sides
  task automatic test_random_traffic();
    bit    filling;
    int    r;
    cmd_e  cmd;
    data_t item;
    data_t anchor;
    value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'sd0, -32'sd1,
                   $urandom, $urandom, $urandom, $urandom};
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) begin
        tx_steady  = ($urandom_range(0, 3) == 0);
        rx_mode    = rx_mode_e'($urandom_range(0, 2));
        burst_left = 0;
      end
      if (model_entries.size() >= CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (model_entries.size() == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      if (n % 30 == 29) filling = !filling;
      r = $urandom_range(0, 99);
      if (filling)
        cmd = (r < 50) ? CMD_APPEND : (r < 75) ? CMD_INSERT : (r < 85) ? CMD_DELETE
                                                                       : CMD_READ_ALL;
      else
        cmd = (r < 10) ? CMD_APPEND : (r < 25) ? CMD_INSERT : (r < 85) ? CMD_DELETE
                                                                       : CMD_READ_ALL;
      item   = $urandom;
      anchor = $urandom;
      case (cmd)
        CMD_APPEND: item = pick_value(20);
        CMD_INSERT: begin
          item   = pick_value(20);
          anchor = pick_value(80);
        end
        CMD_DELETE: item = pick_value(75);
        default: ;
      endcase
      send_item(cmd, item, anchor);
    end
  endtask

  // receiver parks a result for a long time while commands keep coming,
  // so the engine stalls and stops taking commands
  task automatic test_result_backpressure();
    tx_steady  = 1'b1;
    burst_left = 0;
    rx_mode    = RX_ALWAYS;
    hold_req   = 1'b1;
    for (int n = 0; n < PRESSURE_ITEMS; n++) begin
      if (n % 4 == 3) send_item(CMD_READ_ALL, $urandom, $urandom);
      else send_item(CMD_APPEND, pick_value(30), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count         = 0;
    result_index        = 0;
    burst_left          = 0;
    tx_steady           = 1'b0;
    hold_req            = 1'b0;
    rx_mode             = RX_RANDOM;
    value_pool          = '{default: '0};
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_APPEND;
    cmd_ch.item_value   = '0;
    cmd_ch.anchor_value = '0;
    rst_n               = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_list();
    test_fill_and_full();
    test_delete_cases();
    test_random_traffic();
    test_result_backpressure();

    // all commands taken; let the receiver drain the rest
    cmd_ch.valid = 1'b0;
    rx_mode      = RX_RANDOM;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
